// ===== sv/tpc_pkg.sv =====
// Package: widths, register codes, reset values and shared types for the three-axis PID
`default_nettype none
package tpc_pkg;

  localparam int RATE_BITS  = 24;
  localparam int GAIN_W     = 24;
  localparam int LIMIT_W    = 11;
  localparam int DRIVE_W    = 20;
  localparam int FRAC_SHIFT = 16;
  localparam int ROUND_HALF = 32768;
  localparam int LIM_FRAC   = 8;
  localparam int NUM_AXES   = 3;

  localparam int ERR_W      = RATE_BITS + 1;
  localparam int DIFF_W     = RATE_BITS + 2;
  localparam int PROD_I_W   = GAIN_W + 1 + ERR_W;
  localparam int PROD_P_W   = GAIN_W + 1 + ERR_W;
  localparam int PROD_D_W   = GAIN_W + 1 + DIFF_W;
  localparam int IR_SUM_W   = PROD_I_W + 1;
  localparam int PD_SUM_W   = PROD_D_W + 1;
  localparam int IR_W       = IR_SUM_W - FRAC_SHIFT;
  localparam int PDR_W      = PD_SUM_W - FRAC_SHIFT;
  localparam int INTEG_W    = LIMIT_W + LIM_FRAC + 1;
  localparam int INT_SUM_W  = IR_W + 1;
  localparam int OUT_SUM_W  = PDR_W + 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = GAIN_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_P_GAIN_RP = 3'd0,
    REG_I_GAIN_RP = 3'd1,
    REG_D_GAIN_RP = 3'd2,
    REG_LIMIT_RP  = 3'd3,
    REG_P_GAIN_Y  = 3'd4,
    REG_I_GAIN_Y  = 3'd5,
    REG_D_GAIN_Y  = 3'd6,
    REG_LIMIT_Y   = 3'd7
  } cfg_reg_e;

  localparam logic [GAIN_W-1:0]  RST_P_GAIN_RP = GAIN_W'(91750);
  localparam logic [GAIN_W-1:0]  RST_I_GAIN_RP = GAIN_W'(3277);
  localparam logic [GAIN_W-1:0]  RST_D_GAIN_RP = GAIN_W'(983040);
  localparam logic [LIMIT_W-1:0] RST_LIMIT_RP  = LIMIT_W'(400);
  localparam logic [GAIN_W-1:0]  RST_P_GAIN_Y  = GAIN_W'(262144);
  localparam logic [GAIN_W-1:0]  RST_I_GAIN_Y  = GAIN_W'(1311);
  localparam logic [GAIN_W-1:0]  RST_D_GAIN_Y  = GAIN_W'(0);
  localparam logic [LIMIT_W-1:0] RST_LIMIT_Y   = LIMIT_W'(400);

  typedef struct packed {
    logic [GAIN_W-1:0]  p_gain;
    logic [GAIN_W-1:0]  i_gain;
    logic [GAIN_W-1:0]  d_gain;
    logic [LIMIT_W-1:0] limit;
  } gain_set_t;

  typedef struct packed {
    gain_set_t rp;
    gain_set_t yaw;
  } tpc_cfg_t;

  typedef struct packed {
    logic adv1;
    logic adv2;
    logic adv3;
    logic restart1;
    logic restart3;
  } tpc_ctrl_t;

endpackage
`default_nettype wire

// ===== sv/tpc_in_if.sv =====
// Interface: input channel carrying rates, targets and the restart flag
`default_nettype none
interface tpc_in_if
  import tpc_pkg::*;
();
  logic                        valid;
  logic                        ready;
  logic signed [RATE_BITS-1:0] roll_rate;
  logic signed [RATE_BITS-1:0] pitch_rate;
  logic signed [RATE_BITS-1:0] yaw_rate;
  logic signed [RATE_BITS-1:0] roll_target;
  logic signed [RATE_BITS-1:0] pitch_target;
  logic signed [RATE_BITS-1:0] yaw_target;
  logic                        restart;

  modport source (
    output valid, roll_rate, pitch_rate, yaw_rate,
    output roll_target, pitch_target, yaw_target, restart,
    input  ready
  );
  modport sink (
    input  valid, roll_rate, pitch_rate, yaw_rate,
    input  roll_target, pitch_target, yaw_target, restart,
    output ready
  );
endinterface
`default_nettype wire

// ===== sv/tpc_out_if.sv =====
// Interface: result channel carrying the three clamped drive values
`default_nettype none
interface tpc_out_if
  import tpc_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] roll_drive;
  logic signed [DRIVE_W-1:0] pitch_drive;
  logic signed [DRIVE_W-1:0] yaw_drive;

  modport source (
    output valid, roll_drive, pitch_drive, yaw_drive,
    input  ready
  );
  modport sink (
    input  valid, roll_drive, pitch_drive, yaw_drive,
    output ready
  );
endinterface
`default_nettype wire

// ===== sv/tpc_cfg_regs.sv =====
// Configuration register file: gain sets and limits, written by index
`default_nettype none
module tpc_cfg_regs
  import tpc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output tpc_cfg_t                   cfg
);

  tpc_cfg_t cfg_r;
  tpc_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_reg_e'(cfg_idx))
        REG_P_GAIN_RP: cfg_nxt.rp.p_gain  = cfg_data[GAIN_W-1:0];
        REG_I_GAIN_RP: cfg_nxt.rp.i_gain  = cfg_data[GAIN_W-1:0];
        REG_D_GAIN_RP: cfg_nxt.rp.d_gain  = cfg_data[GAIN_W-1:0];
        REG_LIMIT_RP:  cfg_nxt.rp.limit   = cfg_data[LIMIT_W-1:0];
        REG_P_GAIN_Y:  cfg_nxt.yaw.p_gain = cfg_data[GAIN_W-1:0];
        REG_I_GAIN_Y:  cfg_nxt.yaw.i_gain = cfg_data[GAIN_W-1:0];
        REG_D_GAIN_Y:  cfg_nxt.yaw.d_gain = cfg_data[GAIN_W-1:0];
        REG_LIMIT_Y:   cfg_nxt.yaw.limit  = cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rp.p_gain  <= RST_P_GAIN_RP;
      cfg_r.rp.i_gain  <= RST_I_GAIN_RP;
      cfg_r.rp.d_gain  <= RST_D_GAIN_RP;
      cfg_r.rp.limit   <= RST_LIMIT_RP;
      cfg_r.yaw.p_gain <= RST_P_GAIN_Y;
      cfg_r.yaw.i_gain <= RST_I_GAIN_Y;
      cfg_r.yaw.d_gain <= RST_D_GAIN_Y;
      cfg_r.yaw.limit  <= RST_LIMIT_Y;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ===== sv/tpc_axis.sv =====
// One axis datapath: error, products, rounding, integrator and output clamps
`default_nettype none
module tpc_axis
  import tpc_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire tpc_ctrl_t                   ctrl,
  input  wire logic signed [RATE_BITS-1:0] rate,
  input  wire logic signed [RATE_BITS-1:0] target,
  input  wire gain_set_t                   gains,
  output logic signed [DRIVE_W-1:0]        drive
);

  // stage 2 inputs: error and derivative difference
  logic signed [ERR_W-1:0]     err;
  logic signed [ERR_W-1:0]     prev_eff;
  logic signed [DIFF_W-1:0]    diff;
  logic signed [ERR_W-1:0]     prev_r;
  logic signed [PROD_I_W-1:0]  prod_i_nxt, prod_i_r;
  logic signed [PROD_P_W-1:0]  prod_p_nxt, prod_p_r;
  logic signed [PROD_D_W-1:0]  prod_d_nxt, prod_d_r;

  // stage 3: rounding to Q.8
  logic signed [IR_SUM_W-1:0]  ir_sum;
  logic signed [PD_SUM_W-1:0]  pd_sum;
  logic signed [IR_W-1:0]      ir_nxt, ir_r;
  logic signed [PDR_W-1:0]     pdr_nxt, pdr_r;

  // stage 4: integrator and output clamps
  logic signed [INTEG_W-1:0]   integ_r, integ_nxt, integ_base;
  logic signed [INT_SUM_W-1:0] isum, ilim;
  logic signed [OUT_SUM_W-1:0] osum, olim;
  logic signed [DRIVE_W-1:0]   drive_r, drive_nxt;

  always_comb begin
    err        = {rate[RATE_BITS-1], rate} - {target[RATE_BITS-1], target};
    prev_eff   = ctrl.restart1 ? '0 : prev_r;
    diff       = {err[ERR_W-1], err} - {prev_eff[ERR_W-1], prev_eff};
    prod_i_nxt = $signed({1'b0, gains.i_gain}) * err;
    prod_p_nxt = $signed({1'b0, gains.p_gain}) * err;
    prod_d_nxt = $signed({1'b0, gains.d_gain}) * diff;
  end

  always_comb begin
    ir_sum  = IR_SUM_W'(prod_i_r) + IR_SUM_W'(ROUND_HALF);
    pd_sum  = PD_SUM_W'(prod_p_r) + PD_SUM_W'(prod_d_r) + PD_SUM_W'(ROUND_HALF);
    ir_nxt  = IR_W'(ir_sum >>> FRAC_SHIFT);
    pdr_nxt = PDR_W'(pd_sum >>> FRAC_SHIFT);
  end

  always_comb begin
    integ_base = ctrl.restart3 ? '0 : integ_r;
    ilim       = $signed(INT_SUM_W'({gains.limit, LIM_FRAC'(0)}));
    isum       = INT_SUM_W'(ir_r) + INT_SUM_W'(integ_base);
    if (isum > ilim) begin
      integ_nxt = INTEG_W'(ilim);
    end else if (isum < -ilim) begin
      integ_nxt = INTEG_W'(-ilim);
    end else begin
      integ_nxt = INTEG_W'(isum);
    end
    olim = $signed(OUT_SUM_W'({gains.limit, LIM_FRAC'(0)}));
    osum = OUT_SUM_W'(pdr_r) + OUT_SUM_W'(integ_nxt);
    if (osum > olim) begin
      drive_nxt = DRIVE_W'(olim);
    end else if (osum < -olim) begin
      drive_nxt = DRIVE_W'(-olim);
    end else begin
      drive_nxt = DRIVE_W'(osum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      integ_r <= '0;
    end else begin
      if (ctrl.adv1) begin
        prev_r <= err;
      end
      if (ctrl.adv3) begin
        integ_r <= integ_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv1) begin
      prod_i_r <= prod_i_nxt;
      prod_p_r <= prod_p_nxt;
      prod_d_r <= prod_d_nxt;
    end
    if (ctrl.adv2) begin
      ir_r  <= ir_nxt;
      pdr_r <= pdr_nxt;
    end
    if (ctrl.adv3) begin
      drive_r <= drive_nxt;
    end
  end

  assign drive = drive_r;

endmodule
`default_nettype wire

// ===== sv/three_axis_pid_with_clamps.sv =====
// Top level: three-axis rate PID with integrator and output clamps
//
//   channel | dir | handshake          | payload
//   in_ch   | in  | valid / ready      | roll/pitch/yaw rate and target, restart
//   out_ch  | out | valid / ready      | roll/pitch/yaw drive
//   cfg_*   | in  | cfg_we             | cfg_idx, cfg_data
//
// One item per cycle while out_ch is not stalled; a result passes the input register,
// product register, rounding register and drive register in turn before it is valid.
// Integrator and previous error feed back within their own stage, so back-to-back
// items see each other's state in order. Reset is synchronous; it clears the
// pipeline valids, the integrators, previous errors and loads register defaults.
// A stalled output holds its stage; earlier stages keep filling bubbles.
`default_nettype none
module three_axis_pid_with_clamps
  import tpc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  tpc_in_if.sink                     in_ch,
  tpc_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  tpc_cfg_t  cfg;
  tpc_ctrl_t ctrl;

  logic v1_r, v2_r, v3_r, v4_r;
  logic rst1_r, rst2_r, rst3_r;
  logic adv1, adv2, adv3, in_xfer;
  logic signed [RATE_BITS-1:0] rate_r   [NUM_AXES];
  logic signed [RATE_BITS-1:0] target_r [NUM_AXES];
  logic signed [DRIVE_W-1:0]   drive    [NUM_AXES];

  tpc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  always_comb begin
    adv3         = v3_r && (!v4_r || out_ch.ready);
    adv2         = v2_r && (!v3_r || adv3);
    adv1         = v1_r && (!v2_r || adv2);
    in_ch.ready  = !v1_r || adv1;
    in_xfer      = in_ch.valid && in_ch.ready;
    ctrl.adv1     = adv1;
    ctrl.adv2     = adv2;
    ctrl.adv3     = adv3;
    ctrl.restart1 = rst1_r;
    ctrl.restart3 = rst3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        v1_r <= 1'b1;
      end else if (adv1) begin
        v1_r <= 1'b0;
      end
      if (adv1) begin
        v2_r <= 1'b1;
      end else if (adv2) begin
        v2_r <= 1'b0;
      end
      if (adv2) begin
        v3_r <= 1'b1;
      end else if (adv3) begin
        v3_r <= 1'b0;
      end
      if (adv3) begin
        v4_r <= 1'b1;
      end else if (out_ch.ready) begin
        v4_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rate_r[0]   <= in_ch.roll_rate;
      rate_r[1]   <= in_ch.pitch_rate;
      rate_r[2]   <= in_ch.yaw_rate;
      target_r[0] <= in_ch.roll_target;
      target_r[1] <= in_ch.pitch_target;
      target_r[2] <= in_ch.yaw_target;
      rst1_r      <= in_ch.restart;
    end
    if (adv1) begin
      rst2_r <= rst1_r;
    end
    if (adv2) begin
      rst3_r <= rst2_r;
    end
  end

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    tpc_axis u_axis (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl   (ctrl),
      .rate   (rate_r[a]),
      .target (target_r[a]),
      .gains  ((a == NUM_AXES - 1) ? cfg.yaw : cfg.rp),
      .drive  (drive[a])
    );
  end

  assign out_ch.valid       = v4_r;
  assign out_ch.roll_drive  = drive[0];
  assign out_ch.pitch_drive = drive[1];
  assign out_ch.yaw_drive   = drive[2];

  logic signed [DRIVE_W:0] lim_rp, lim_y;
  assign lim_rp = $signed((DRIVE_W + 1)'({cfg.rp.limit, LIM_FRAC'(0)}));
  assign lim_y  = $signed((DRIVE_W + 1)'({cfg.yaw.limit, LIM_FRAC'(0)}));

  a_roll_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((DRIVE_W + 1)'(out_ch.roll_drive) <= lim_rp) &&
                     ((DRIVE_W + 1)'(out_ch.roll_drive) >= -lim_rp))
    else $error("roll drive outside clamp");

  a_yaw_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((DRIVE_W + 1)'(out_ch.yaw_drive) <= lim_y) &&
                     ((DRIVE_W + 1)'(out_ch.yaw_drive) >= -lim_y))
    else $error("yaw drive outside clamp");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && v2_r && v3_r && v4_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("input accepted into a full stalled pipeline");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    adv3 |=> out_ch.valid)
    else $error("stage three transfer lost");

endmodule
`default_nettype wire

// ===== verif/three_axis_pid_with_clamps_tb.sv =====
// Testbench: three-axis PID with clamps, predicted drives checked against every output transfer
`timescale 1ns / 1ps
module three_axis_pid_with_clamps_tb;
  import tpc_pkg::*;

  typedef struct packed {
    logic [NUM_AXES-1:0][RATE_BITS-1:0] rate;
    logic [NUM_AXES-1:0][RATE_BITS-1:0] target;
    logic                               restart;
  } pid_sample_t;

  typedef logic [NUM_AXES-1:0][DRIVE_W-1:0] drive_set_t;

  typedef struct {
    longint integ;
    longint last_err;
  } axis_acc_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  tpc_in_if  in_ch();
  tpc_out_if out_ch();

  three_axis_pid_with_clamps u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  tpc_cfg_t   gains;
  axis_acc_t  axis_acc [NUM_AXES];
  drive_set_t expected_drives [$];
  int         errors;
  bit         no_idle;
  string      axis_name [NUM_AXES] = '{"roll", "pitch", "yaw"};

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic longint round_q8(longint x);
    return (x + ROUND_HALF) >>> FRAC_SHIFT;
  endfunction

  function automatic longint clamp_sym(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic drive_set_t predict_drives(pid_sample_t s);
    drive_set_t d;
    gain_set_t  g;
    longint     err;
    longint     lim;
    longint     pd;
    if (s.restart) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        axis_acc[a].integ = 0;
        axis_acc[a].last_err = 0;
      end
    end
    for (int a = 0; a < NUM_AXES; a++) begin
      g = (a == NUM_AXES - 1) ? gains.yaw : gains.rp;
      lim = longint'(g.limit) * (longint'(1) << LIM_FRAC);
      err = longint'($signed(s.rate[a])) - longint'($signed(s.target[a]));
      axis_acc[a].integ = clamp_sym(axis_acc[a].integ + round_q8(longint'(g.i_gain) * err), lim);
      pd = longint'(g.p_gain) * err + longint'(g.d_gain) * (err - axis_acc[a].last_err);
      d[a] = DRIVE_W'(clamp_sym(round_q8(pd) + axis_acc[a].integ, lim));
      axis_acc[a].last_err = err;
    end
    return d;
  endfunction

  function automatic pid_sample_t mk_sample(
    input logic [RATE_BITS-1:0] rr, pr, yr, rt, pt, yt,
    input logic rs
  );
    pid_sample_t s;
    s.rate   = {yr, pr, rr};
    s.target = {yt, pt, rt};
    s.restart = rs;
    return s;
  endfunction

  function automatic int rand_span(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return GAIN_W'($urandom);
      default: return GAIN_W'($urandom_range(32'h3FFFF));
    endcase
  endfunction

  // Called and returns right after a falling edge.
  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      REG_P_GAIN_RP: gains.rp.p_gain  = data;
      REG_I_GAIN_RP: gains.rp.i_gain  = data;
      REG_D_GAIN_RP: gains.rp.d_gain  = data;
      REG_LIMIT_RP:  gains.rp.limit   = data[LIMIT_W-1:0];
      REG_P_GAIN_Y:  gains.yaw.p_gain = data;
      REG_I_GAIN_Y:  gains.yaw.i_gain = data;
      REG_D_GAIN_Y:  gains.yaw.d_gain = data;
      REG_LIMIT_Y:   gains.yaw.limit  = data[LIMIT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_default_gains();
    write_reg(REG_P_GAIN_RP, RST_P_GAIN_RP);
    write_reg(REG_I_GAIN_RP, RST_I_GAIN_RP);
    write_reg(REG_D_GAIN_RP, RST_D_GAIN_RP);
    write_reg(REG_LIMIT_RP, CFG_DATA_W'(RST_LIMIT_RP));
    write_reg(REG_P_GAIN_Y, RST_P_GAIN_Y);
    write_reg(REG_I_GAIN_Y, RST_I_GAIN_Y);
    write_reg(REG_D_GAIN_Y, RST_D_GAIN_Y);
    write_reg(REG_LIMIT_Y, CFG_DATA_W'(RST_LIMIT_Y));
  endtask

  task automatic apply_sample(pid_sample_t s);
    if (!no_idle && $urandom_range(99) < 29) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.roll_rate    <= s.rate[0];
    in_ch.pitch_rate   <= s.rate[1];
    in_ch.yaw_rate     <= s.rate[2];
    in_ch.roll_target  <= s.target[0];
    in_ch.pitch_target <= s.target[1];
    in_ch.yaw_target   <= s.target[2];
    in_ch.restart      <= s.restart;
    do @(posedge clk); while (!in_ch.ready);
    expected_drives.push_back(predict_drives(s));
    @(negedge clk);
  endtask

  task automatic wait_for_drives();
    int waited;
    waited = 0;
    in_ch.valid <= 1'b0;
    while (expected_drives.size() != 0 && waited < 5000) begin
      @(negedge clk);
      waited++;
    end
    repeat (6) @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_ch.ready <= no_idle || ($urandom_range(99) >= 29);
  end

  always @(posedge clk) begin
    drive_set_t got;
    drive_set_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.yaw_drive, out_ch.pitch_drive, out_ch.roll_drive};
      if (expected_drives.size() == 0) begin
        $display("%0t unexpected drive transfer: roll %0d pitch %0d yaw %0d", $time,
                 $signed(got[0]), $signed(got[1]), $signed(got[2]));
        errors++;
      end else begin
        want = expected_drives.pop_front();
        for (int a = 0; a < NUM_AXES; a++) begin
          if (got[a] !== want[a]) begin
            $display("%0t %s_drive expected %0d actual %0d", $time, axis_name[a],
                     $signed(want[a]), $signed(got[a]));
            errors++;
          end
        end
      end
    end
  end

  task automatic test_default_gains();
    apply_sample(mk_sample(0, 0, 0, 0, 0, 0, 1'b0));
    apply_sample(mk_sample(24'sd256, -24'sd512, 24'sd1024, 0, 0, 0, 1'b0));
    apply_sample(mk_sample(24'sd256, -24'sd512, 24'sd1024, 0, 0, 0, 1'b0));
    apply_sample(mk_sample(24'sd300, 24'sd300, -24'sd700, 24'sd100, 0, 0, 1'b0));
    wait_for_drives();
  endtask

  task automatic test_field_extremes();
    for (int k = 0; k < 8; k++)
      write_reg(cfg_reg_e'(k), (k % 4 == 3) ? CFG_DATA_W'(2047) : '1);
    apply_sample(mk_sample(24'h7FFFFF, 24'h800000, 24'h7FFFFF,
                           24'h800000, 24'h7FFFFF, 24'h800000, 1'b0));
    apply_sample(mk_sample(24'h800000, 24'h7FFFFF, 24'h800000,
                           24'h7FFFFF, 24'h800000, 24'h7FFFFF, 1'b0));
    apply_sample(mk_sample(24'h800000, 24'h800000, 24'h7FFFFF,
                           24'h800000, 24'h800000, 24'h7FFFFF, 1'b1));
    apply_sample(mk_sample(24'h555555, 24'hAAAAAA, 24'h000001,
                           24'hAAAAAA, 24'h555555, 24'hFFFFFF, 1'b0));
    wait_for_drives();
  endtask

  task automatic test_zero_limit();
    write_reg(REG_LIMIT_RP, '0);
    write_reg(REG_LIMIT_Y, '0);
    apply_sample(mk_sample(24'h7FFFFF, 24'h800000, 24'h123456, 0, 0, 0, 1'b0));
    apply_sample(mk_sample(24'h800000, 24'h7FFFFF, 24'hABCDEF, 0, 0, 0, 1'b0));
    wait_for_drives();
  endtask

  task automatic test_limit_lowered();
    write_reg(REG_P_GAIN_RP, '0);
    write_reg(REG_I_GAIN_RP, 24'h010000);
    write_reg(REG_D_GAIN_RP, '0);
    write_reg(REG_LIMIT_RP, CFG_DATA_W'(2047));
    write_reg(REG_P_GAIN_Y, '0);
    write_reg(REG_I_GAIN_Y, 24'h010000);
    write_reg(REG_D_GAIN_Y, '0);
    write_reg(REG_LIMIT_Y, CFG_DATA_W'(2047));
    repeat (3) apply_sample(mk_sample(24'sd256000, -24'sd256000, 24'sd256000, 0, 0, 0, 1'b0));
    wait_for_drives();
    write_reg(REG_LIMIT_RP, CFG_DATA_W'(100));
    write_reg(REG_LIMIT_Y, CFG_DATA_W'(1));
    apply_sample(mk_sample(0, 0, 0, 0, 0, 0, 1'b0));
    apply_sample(mk_sample(-24'sd5000, 24'sd5000, -24'sd200, 0, 0, 0, 1'b0));
    wait_for_drives();
  endtask

  // Upper data bits beyond the 11-bit limit must be dropped.
  task automatic test_wide_writes();
    write_reg(REG_LIMIT_RP, 24'hABC123);
    write_reg(REG_LIMIT_Y, 24'h5557FF);
    apply_sample(mk_sample(24'sd90000, -24'sd90000, 24'sd400000, 0, 0, 0, 1'b0));
    apply_sample(mk_sample(-24'sd90000, 24'sd90000, -24'sd400000, 0, 0, 0, 1'b0));
    wait_for_drives();
  endtask

  task automatic test_restart();
    load_default_gains();
    apply_sample(mk_sample(24'sd2560, -24'sd2560, 24'sd5120, 0, 0, 0, 1'b0));
    apply_sample(mk_sample(24'sd2560, -24'sd2560, 24'sd5120, 0, 0, 0, 1'b0));
    apply_sample(mk_sample(24'sd2560, -24'sd2560, 24'sd5120, 0, 0, 0, 1'b1));
    apply_sample(mk_sample(0, 0, 0, 0, 0, 0, 1'b0));
    wait_for_drives();
  endtask

  task automatic test_random();
    pid_sample_t s;
    int          setpoint [NUM_AXES];
    int          kind;
    cfg_reg_e    idx;
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 0) begin
        load_default_gains();
      end else begin
        for (int k = 0; k < 8; k++) begin
          idx = cfg_reg_e'(k);
          if (idx == REG_LIMIT_RP || idx == REG_LIMIT_Y)
            write_reg(idx, (phase == 1) ? CFG_DATA_W'(2047) : CFG_DATA_W'($urandom));
          else
            write_reg(idx, (phase == 1) ? '1 : pick_gain());
        end
      end
      no_idle = (phase == 3);
      for (int a = 0; a < NUM_AXES; a++) setpoint[a] = rand_span(1 << 20);
      for (int n = 0; n < 325; n++) begin
        kind = $urandom_range(99);
        if ($urandom_range(99) < 5)
          for (int a = 0; a < NUM_AXES; a++) setpoint[a] = rand_span(1 << 20);
        for (int a = 0; a < NUM_AXES; a++) begin
          if (kind < 15) begin
            s.rate[a]   = RATE_BITS'($urandom);
            s.target[a] = RATE_BITS'($urandom);
          end else begin
            s.target[a] = RATE_BITS'(setpoint[a]);
            s.rate[a]   = RATE_BITS'(setpoint[a] + rand_span(1 << 12));
          end
        end
        s.restart = ($urandom_range(99) < 3);
        apply_sample(s);
      end
      wait_for_drives();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    errors = 0;
    no_idle = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_P_GAIN_RP;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.roll_rate = '0;
    in_ch.pitch_rate = '0;
    in_ch.yaw_rate = '0;
    in_ch.roll_target = '0;
    in_ch.pitch_target = '0;
    in_ch.yaw_target = '0;
    in_ch.restart = 1'b0;
    out_ch.ready = 1'b0;
    gains.rp  = '{RST_P_GAIN_RP, RST_I_GAIN_RP, RST_D_GAIN_RP, RST_LIMIT_RP};
    gains.yaw = '{RST_P_GAIN_Y, RST_I_GAIN_Y, RST_D_GAIN_Y, RST_LIMIT_Y};
    for (int a = 0; a < NUM_AXES; a++) begin
      axis_acc[a].integ = 0;
      axis_acc[a].last_err = 0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_default_gains();
    test_field_extremes();
    test_zero_limit();
    test_limit_lowered();
    test_wide_writes();
    test_restart();
    test_random();

    if (expected_drives.size() != 0) begin
      $display("%0t %0d drive transfers never arrived", $time, expected_drives.size());
      errors++;
    end
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/tpc_pkg.sv
sv/tpc_in_if.sv
sv/tpc_out_if.sv
sv/tpc_cfg_regs.sv
sv/tpc_axis.sv
sv/three_axis_pid_with_clamps.sv
verif/three_axis_pid_with_clamps_tb.sv
